// ===== rtl/sgd_pkg.sv =====
// sgd_pkg: shared types, constants and helpers of the sobel gradient/direction core
// depends on nothing; used by sobel_gradient_direction_core
`default_nettype none

package sgd_pkg;

    // frame limits and derived widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 11;
    localparam int ROW_W      = 16;
    localparam int PIX_W      = 8;
    localparam int MAG_W      = 11;
    localparam int DIR_W      = 2;
    localparam int SUM_W      = 10;
    localparam int PROD_W     = 20;

    localparam logic [ROW_W-1:0] ROW_CAP      = 16'hFFFF;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;

    // tangent thresholds on a 1/256 scale
    localparam logic [9:0] TAN23_Q8 = 10'd109;
    localparam logic [9:0] TAN67_Q8 = 10'd603;
    localparam logic [9:0] TAN68_Q8 = 10'd634;

    typedef enum logic
    {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic
    {
        MODE_PIXEL = 1'b0,
        MODE_FLUSH = 1'b1
    } mode_t;

    typedef enum logic [DIR_W-1:0]
    {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } dir_bin_t;

    // frame border flags of one output position; right also marks end of row
    typedef struct packed
    {
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic eof;
    } border_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
                r = DIM_W'(1);
            else if (v > maxv)
                r = maxv;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sgd_ram.sv =====
// sgd_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`default_nettype none

module sgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sobel_gradient_direction_core.sv =====
// sobel_gradient_direction_core: streaming 3x3 sobel magnitude and direction bin
// depends on sgd_pkg and sgd_ram (two line buffers)
//
// usage:
//   input stream s_*: one request per pixel in raster order, s_tdata = grey pixel,
//   s_tuser = 0 for a pixel, 1 for a flush tick. after the last pixel of a frame,
//   frame_width + 1 flush ticks push out the pending bottom row. pixels after the
//   frame is complete and flush ticks before it are taken and dropped.
//   output stream m_*: one result per pixel position, lagging the input by one row
//   plus one pixel. m_tlast marks the end of a row, m_tuser the end of the frame.
//   config port: frame_width (index 0) and frame_height (index 1), saturated to
//   1..1024; write only while the block is idle.
// timing: one request per clock sustained while m_tready stays high; an accepted request
//   passes the line buffer read on the accepting edge, then the window register, then
//   the result register. each line buffer takes one read and one write per clock,
//   which sustains one pixel per clock.
// reset: counters, window and valid bits clear, frame size returns to 640 x 480;
//   line buffers are not cleared, unwritten entries only feed masked neighbors.
// stall: when m_tready is low the pipeline fills its empty stages, then s_tready
//   drops; no request is lost.
`default_nettype none

module sobel_gradient_direction_core (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // input stream
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] grey_pixel
    input  wire logic                     s_tuser,   // [0] mode
    // output stream
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [15:0]              m_tdata,   // [10:0] magnitude, [12:11] direction_bin
    output logic                          m_tlast,   // end_of_row
    output logic                          m_tuser,   // [0] end_of_frame
    // config write port
    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_index,
    input  wire logic [sgd_pkg::DIM_W-1:0] cfg_data
);

    // ---------------- config and position counters ----------------
    logic [sgd_pkg::DIM_W-1:0] frame_width_reg;
    logic [sgd_pkg::DIM_W-1:0] frame_height_reg;

    logic [sgd_pkg::COL_W-1:0] in_column_reg, in_column_next;
    logic [sgd_pkg::ROW_W-1:0] in_row_reg, in_row_next;
    logic [sgd_pkg::COL_W-1:0] out_column_reg, out_column_next;
    logic [sgd_pkg::ROW_W-1:0] out_row_reg, out_row_next;

    // pipeline handshake
    logic out_valid_reg;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic adv_out;
    logic adv2;
    logic adv1;

    assign adv_out  = !out_valid_reg || m_tready;
    assign adv2     = adv_out || !s2_valid_reg;
    assign adv1     = adv2 || !s1_valid_reg;
    assign s_tready = adv1;

    // ---------------- stage 0: request decode and counters ----------------
    sgd_pkg::mode_t             mode;
    logic                       accept;
    logic                       frame_in;
    logic                       ignore_req;
    logic                       take;
    logic                       col_end;
    logic                       primed;
    logic [sgd_pkg::PIX_W-1:0]  pixel_in;
    sgd_pkg::border_t           border0;

    assign mode       = sgd_pkg::mode_t'(s_tuser);
    assign accept     = s_tvalid && s_tready;
    assign frame_in   = in_row_reg >= sgd_pkg::ROW_W'(frame_height_reg);
    assign ignore_req = (mode == sgd_pkg::MODE_PIXEL) ? frame_in : !frame_in;
    assign take       = accept && !ignore_req;
    assign pixel_in   = (mode == sgd_pkg::MODE_FLUSH) ? '0 : s_tdata;

    assign col_end = (sgd_pkg::DIM_W'(in_column_reg) + sgd_pkg::DIM_W'(1)) >= frame_width_reg;
    assign primed  = (in_row_reg >= sgd_pkg::ROW_W'(2))
                  || ((in_row_reg == sgd_pkg::ROW_W'(1)) && (in_column_reg != '0));

    always_comb
    begin
        border0.top    = out_row_reg == '0;
        border0.bottom = ({1'b0, out_row_reg} + (sgd_pkg::ROW_W + 1)'(1))
                         >= (sgd_pkg::ROW_W + 1)'(frame_height_reg);
        border0.left   = out_column_reg == '0;
        border0.right  = (sgd_pkg::DIM_W'(out_column_reg) + sgd_pkg::DIM_W'(1))
                         >= frame_width_reg;
        border0.eof    = border0.right && border0.bottom;
    end

    always_comb
    begin
        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        if (take)
        begin
            if (col_end)
            begin
                in_column_next = '0;
                if (in_row_reg < sgd_pkg::ROW_CAP)
                begin
                    in_row_next = in_row_reg + sgd_pkg::ROW_W'(1);
                end
            end
            else
            begin
                in_column_next = in_column_reg + sgd_pkg::COL_W'(1);
            end
            if (primed)
            begin
                if (border0.right)
                begin
                    out_column_next = '0;
                    if (out_row_reg < sgd_pkg::ROW_CAP)
                    begin
                        out_row_next = out_row_reg + sgd_pkg::ROW_W'(1);
                    end
                end
                else
                begin
                    out_column_next = out_column_reg + sgd_pkg::COL_W'(1);
                end
                if (border0.eof)
                begin
                    in_column_next  = '0;
                    in_row_next     = '0;
                    out_column_next = '0;
                    out_row_next    = '0;
                end
            end
        end
    end

    // ---------------- stage 1: line buffer read ----------------
    logic                      s1_primed_reg;
    sgd_pkg::border_t          s1_border_reg;
    logic [sgd_pkg::COL_W-1:0] s1_col_reg;
    logic [sgd_pkg::PIX_W-1:0] s1_pixel_reg;
    logic                      fwd_reg;
    logic [sgd_pkg::PIX_W-1:0] prev_pixel_reg;
    logic [sgd_pkg::PIX_W-1:0] prev_above_reg;
    logic [sgd_pkg::PIX_W-1:0] ram_above;
    logic [sgd_pkg::PIX_W-1:0] ram_two;
    logic [sgd_pkg::PIX_W-1:0] above;
    logic [sgd_pkg::PIX_W-1:0] two;
    logic                      s1_write;
    logic                      fwd_next;

    assign s1_write = s1_valid_reg && adv2;
    // same column written by the leaving request while this one reads it
    assign fwd_next = take && s1_write && (s1_col_reg == in_column_reg);
    assign above    = fwd_reg ? prev_pixel_reg : ram_above;
    assign two      = fwd_reg ? prev_above_reg : ram_two;

    // row above the current one
    sgd_ram #(
        .WIDTH (sgd_pkg::PIX_W),
        .DEPTH (sgd_pkg::MAX_WIDTH)
    ) u_line_above (
        .clk   (clk),
        .we    (s1_write),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .re    (take),
        .raddr (in_column_reg),
        .rdata (ram_above)
    );

    // row two above the current one
    sgd_ram #(
        .WIDTH (sgd_pkg::PIX_W),
        .DEPTH (sgd_pkg::MAX_WIDTH)
    ) u_line_two (
        .clk   (clk),
        .we    (s1_write),
        .waddr (s1_col_reg),
        .wdata (above),
        .re    (take),
        .raddr (in_column_reg),
        .rdata (ram_two)
    );

    // ---------------- stage 2: window and sobel ----------------
    logic [sgd_pkg::PIX_W-1:0] window_reg [9];
    sgd_pkg::border_t          s2_border_reg;
    logic [sgd_pkg::PIX_W-1:0] p [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            p[i] = window_reg[i];
        end
        if (s2_border_reg.top)
        begin
            p[0] = '0;
            p[1] = '0;
            p[2] = '0;
        end
        if (s2_border_reg.bottom)
        begin
            p[6] = '0;
            p[7] = '0;
            p[8] = '0;
        end
        if (s2_border_reg.left)
        begin
            p[0] = '0;
            p[3] = '0;
            p[6] = '0;
        end
        if (s2_border_reg.right)
        begin
            p[2] = '0;
            p[5] = '0;
            p[8] = '0;
        end
    end

    logic [sgd_pkg::SUM_W-1:0]  sum_right, sum_left, sum_bottom, sum_top;
    logic signed [sgd_pkg::SUM_W:0] gx, gy, gx_abs, gy_abs;
    logic [sgd_pkg::SUM_W-1:0]  ax, ay;
    logic [sgd_pkg::MAG_W-1:0]  magnitude;
    logic                       gx_neg, gy_neg, gx_eff_neg;
    logic [sgd_pkg::PROD_W-1:0] ay_q8, ax_t23, ax_t67, ax_t68;
    sgd_pkg::dir_bin_t          dir_bin;

    assign sum_right  = sgd_pkg::SUM_W'(p[2]) + sgd_pkg::SUM_W'({p[5], 1'b0})
                        + sgd_pkg::SUM_W'(p[8]);
    assign sum_left   = sgd_pkg::SUM_W'(p[0]) + sgd_pkg::SUM_W'({p[3], 1'b0})
                        + sgd_pkg::SUM_W'(p[6]);
    assign sum_bottom = sgd_pkg::SUM_W'(p[6]) + sgd_pkg::SUM_W'({p[7], 1'b0})
                        + sgd_pkg::SUM_W'(p[8]);
    assign sum_top    = sgd_pkg::SUM_W'(p[0]) + sgd_pkg::SUM_W'({p[1], 1'b0})
                        + sgd_pkg::SUM_W'(p[2]);

    assign gx     = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
    assign gy     = $signed({1'b0, sum_bottom}) - $signed({1'b0, sum_top});
    assign gx_neg = gx[sgd_pkg::SUM_W];
    assign gy_neg = gy[sgd_pkg::SUM_W];
    assign gx_abs = gx_neg ? -gx : gx;
    assign gy_abs = gy_neg ? -gy : gy;
    assign ax     = gx_abs[sgd_pkg::SUM_W-1:0];
    assign ay     = gy_abs[sgd_pkg::SUM_W-1:0];

    assign magnitude = {1'b0, ax} + {1'b0, ay};

    // angle folded to 0..180: flip both signs when gy is negative
    assign gx_eff_neg = gy_neg ? (!gx_neg && (gx != '0)) : gx_neg;
    assign ay_q8      = sgd_pkg::PROD_W'({ay, 8'b0});
    assign ax_t23     = sgd_pkg::PROD_W'(ax) * sgd_pkg::PROD_W'(sgd_pkg::TAN23_Q8);
    assign ax_t67     = sgd_pkg::PROD_W'(ax) * sgd_pkg::PROD_W'(sgd_pkg::TAN67_Q8);
    assign ax_t68     = sgd_pkg::PROD_W'(ax) * sgd_pkg::PROD_W'(sgd_pkg::TAN68_Q8);

    always_comb
    begin
        priority if (gy == '0)
        begin
            dir_bin = sgd_pkg::DIR_0;
        end
        else if (!gx_eff_neg)
        begin
            priority if (ay_q8 < ax_t23)
                dir_bin = sgd_pkg::DIR_0;
            else if (ay_q8 < ax_t68)
                dir_bin = sgd_pkg::DIR_45;
            else
                dir_bin = sgd_pkg::DIR_90;
        end
        else
        begin
            priority if (ay_q8 > ax_t67)
                dir_bin = sgd_pkg::DIR_90;
            else if (ay_q8 > ax_t23)
                dir_bin = sgd_pkg::DIR_135;
            else
                dir_bin = sgd_pkg::DIR_0;
        end
    end

    // ---------------- output register ----------------
    logic [sgd_pkg::MAG_W-1:0] magnitude_reg;
    sgd_pkg::dir_bin_t         dir_bin_reg;
    logic                      eor_reg;
    logic                      eof_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, dir_bin_reg, magnitude_reg};
    assign m_tlast  = eor_reg;
    assign m_tuser  = eof_reg;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sgd_pkg::WIDTH_RESET;
            frame_height_reg <= sgd_pkg::HEIGHT_RESET;
            in_column_reg    <= '0;
            in_row_reg       <= '0;
            out_column_reg   <= '0;
            out_row_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            fwd_reg          <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (sgd_pkg::cfg_reg_t'(cfg_index))
                    sgd_pkg::REG_FRAME_WIDTH:
                        frame_width_reg <= sgd_pkg::clamp_dim(cfg_data,
                                               sgd_pkg::DIM_W'(sgd_pkg::MAX_WIDTH));
                    sgd_pkg::REG_FRAME_HEIGHT:
                        frame_height_reg <= sgd_pkg::clamp_dim(cfg_data,
                                                sgd_pkg::DIM_W'(sgd_pkg::MAX_HEIGHT));
                    default:
                        frame_width_reg <= frame_width_reg;
                endcase
            end
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
            if (adv1)
            begin
                s1_valid_reg <= take;
                fwd_reg      <= fwd_next;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg && s1_primed_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s1_write)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    window_reg[r*3]     <= window_reg[r*3 + 1];
                    window_reg[r*3 + 1] <= window_reg[r*3 + 2];
                end
                window_reg[2] <= two;
                window_reg[5] <= above;
                window_reg[8] <= s1_pixel_reg;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_primed_reg <= primed;
            s1_border_reg <= border0;
            s1_col_reg    <= in_column_reg;
            s1_pixel_reg  <= pixel_in;
        end
        if (s1_write)
        begin
            prev_pixel_reg <= s1_pixel_reg;
            prev_above_reg <= above;
            s2_border_reg  <= s1_border_reg;
        end
        if (adv_out && s2_valid_reg)
        begin
            magnitude_reg <= magnitude;
            dir_bin_reg   <= dir_bin;
            eor_reg       <= s2_border_reg.right;
            eof_reg       <= s2_border_reg.eof;
        end
    end

`ifndef SYNTHESIS
    // input is refused only when every stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
    else $error("input stalled with an empty pipeline stage");

    // bypass only ever applies to a live request
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_valid_reg)
    else $error("line buffer bypass without a request in stage 1");

    // end of frame restarts all position counters
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && primed && border0.eof) |=>
        (in_column_reg == '0 && in_row_reg == '0
         && out_column_reg == '0 && out_row_reg == '0))
    else $error("counters not cleared after end of frame");

    // a frame end result is always a row end result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eof_reg) |-> eor_reg)
    else $error("end of frame without end of row");

    // magnitude stays within the sobel range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (magnitude_reg <= sgd_pkg::MAG_W'(2040)))
    else $error("magnitude out of range");
`endif

endmodule

`default_nettype wire
